// ===== design/swtq_pkg.sv =====
// Package for the sorted wakeup timer queue.
// Item types, result kinds and fixed limits; no dependencies.
package swtq_pkg;

  localparam int MAX_POPS = 16;
  localparam int POP_W    = $clog2(MAX_POPS + 1);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SLEEP = 1'b1;

  typedef enum logic [1:0] {
    KIND_WOKEN     = 2'd0,
    KIND_QUEUED    = 2'd1,
    KIND_IMMEDIATE = 2'd2,
    KIND_FULL      = 2'd3
  } kind_t;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         sleeper_id;
    logic signed [31:0] sleep_ticks;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  woken_id;
    logic [62:0] due_time;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [63:0] wake;
    logic [7:0]  id;
  } entry_t;

endpackage

// ===== design/sorted_wakeup_timer_queue_core.sv =====
// Sorted wakeup timer queue: tick counter plus a wake-time ordered sleeper queue.
// Depends on swtq_pkg (item types, result kinds, pop limit).
//
// Usage:
//   The input channel (in_valid / in_stall / in_item) takes either a timer tick
//   or a sleep request. The output channel (out_valid / out_stall / out_item)
//   returns the result items, the final one of each input marked by last.
//   A sleep request with non-positive ticks or a full queue answers at once
//   with one item. Otherwise it is inserted by walking the queue from the
//   tail toward the head, one entry per cycle through the single memory read
//   port and one compare unit. The result item is offered once the walk
//   ends and the new entry is written.
//   A tick bumps the count and pops due head entries, one compare per entry,
//   at most 16 pops per tick. A tick with nothing due produces no item; on
//   an empty queue it does not leave idle.
//   in_stall is high until the last result item is taken (or a tick finds
//   nothing due); an output stall holds the result register and sequencer.
//   Reset clears the tick count and empties the queue; memory contents are
//   left as they are and never read before being written.
module sorted_wakeup_timer_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  swtq_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output swtq_pkg::out_item_t out_item
);
  import swtq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TCHK  = 6'b000010,
    ST_TLOOK = 6'b000100,
    ST_SCHK  = 6'b001000,
    ST_SPUT  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t            state;
  logic [63:0]       tick_count;
  logic [OCC_W-1:0]  occupancy;
  logic [IDX_W-1:0]  head;
  logic [OCC_W-1:0]  pos;
  logic [POP_W-1:0]  pop_cnt;
  entry_t            new_entry;
  out_item_t         result;

  // Queue storage: circular buffer, logical slot 0 is the head.
  entry_t            mem [QUEUE_DEPTH];
  entry_t            rd_entry;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              in_acc;
  logic              out_acc;
  logic              sleep_nonpos;
  logic [63:0]       cmp_ref;
  logic              wake_le;
  logic              head_due;
  logic              more_pops;
  logic              shift_up;

  // Map a logical queue slot to its physical memory index.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] hd,
                                            input logic [OCC_W-1:0] lg);
    logic [OCC_W:0] s;
    begin
      s = (OCC_W+1)'(hd) + (OCC_W+1)'(lg);
      if (s >= (OCC_W+1)'(QUEUE_DEPTH)) begin
        s = s - (OCC_W+1)'(QUEUE_DEPTH);
      end
      return s[IDX_W-1:0];
    end
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign out_item  = result;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign sleep_nonpos = (in_item.sleep_ticks == 32'sd0) || in_item.sleep_ticks[31];
  // Single compare unit: the insert walk checks against the new wake time,
  // every other state against the current count.
  assign cmp_ref      = (state == ST_SCHK) ? new_entry.wake : tick_count;
  assign wake_le      = (rd_entry.wake <= cmp_ref);
  // Head entry is due once its wake time is at or before the current count.
  assign head_due     = wake_le;
  // Look ahead only when entries remain and the pop limit is not reached.
  assign more_pops    = (occupancy != OCC_W'(1)) &&
                        ((pop_cnt + POP_W'(1)) != POP_W'(MAX_POPS));
  // Later wake times move one slot toward the tail; equal times stay ahead.
  assign shift_up     = !wake_le;

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head;
    wr_en   = 1'b0;
    wr_addr = phys(head, pos);
    wr_data = rd_entry;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.opcode == OP_TICK) begin
            rd_en   = (occupancy != '0);
            rd_addr = head;
          end else begin
            rd_en   = !sleep_nonpos && (occupancy < OCC_W'(QUEUE_DEPTH)) &&
                      (occupancy != '0);
            rd_addr = phys(head, occupancy - OCC_W'(1));
          end
        end
      end
      ST_TCHK: begin
        rd_en   = head_due && more_pops;
        rd_addr = phys(head, OCC_W'(1));
      end
      ST_SCHK: begin
        if (shift_up) begin
          wr_en   = 1'b1;
          wr_addr = phys(head, pos);
          wr_data = rd_entry;
          rd_en   = (pos != OCC_W'(1));
          rd_addr = phys(head, pos - OCC_W'(2));
        end
      end
      ST_SPUT: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, pos);
        wr_data = new_entry;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      occupancy  <= '0;
      head       <= '0;
      pos        <= '0;
      pop_cnt    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_item.opcode == OP_TICK) begin
              // Advance the count, then look at the head if anything waits.
              tick_count <= tick_count + 64'd1;
              pop_cnt    <= '0;
              if (occupancy != '0) begin
                state <= ST_TCHK;
              end
            end else if (sleep_nonpos) begin
              result.kind     <= KIND_IMMEDIATE;
              result.woken_id <= in_item.sleeper_id;
              result.due_time <= tick_count[62:0];
              result.last     <= 1'b1;
              state           <= ST_EMIT;
            end else if (occupancy >= OCC_W'(QUEUE_DEPTH)) begin
              // Drop the request: queue full.
              result.kind     <= KIND_FULL;
              result.woken_id <= in_item.sleeper_id;
              result.due_time <= tick_count[62:0];
              result.last     <= 1'b1;
              state           <= ST_EMIT;
            end else begin
              new_entry.wake <= tick_count + {32'd0, in_item.sleep_ticks};
              new_entry.id   <= in_item.sleeper_id;
              pos            <= occupancy;
              state          <= (occupancy == '0) ? ST_SPUT : ST_SCHK;
            end
          end
        end
        ST_TCHK: begin
          if (!head_due) begin
            state <= ST_IDLE;
          end else begin
            // Pop the head into the result register.
            result.kind     <= KIND_WOKEN;
            result.woken_id <= rd_entry.id;
            result.due_time <= rd_entry.wake[62:0];
            result.last     <= !more_pops;
            head            <= phys(head, OCC_W'(1));
            occupancy       <= occupancy - OCC_W'(1);
            pop_cnt         <= pop_cnt + POP_W'(1);
            state           <= more_pops ? ST_TLOOK : ST_EMIT;
          end
        end
        ST_TLOOK: begin
          // Next head is now in rd_entry; mark last if it is not yet due.
          result.last <= !head_due;
          state       <= ST_EMIT;
        end
        ST_SCHK: begin
          if (shift_up) begin
            pos <= pos - OCC_W'(1);
            if (pos == OCC_W'(1)) begin
              state <= ST_SPUT;
            end
          end else begin
            state <= ST_SPUT;
          end
        end
        ST_SPUT: begin
          occupancy       <= occupancy + OCC_W'(1);
          result.kind     <= KIND_QUEUED;
          result.woken_id <= new_entry.id;
          result.due_time <= new_entry.wake[62:0];
          result.last     <= 1'b1;
          state           <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_acc) begin
            // rd_entry still holds the due next head when more follow.
            state <= result.last ? ST_IDLE : ST_TCHK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
